// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ptzfb_pkg.sv =====
`default_nettype none
package ptzfb_pkg;

  localparam int OP_W      = 5;
  localparam int PARAM_W   = 8;
  localparam int BYTE_W    = 8;
  localparam int SPEED_W   = 7;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Op codes
  localparam logic [OP_W-1:0] OP_PAN_LEFT    = 5'd0;
  localparam logic [OP_W-1:0] OP_PAN_RIGHT   = 5'd1;
  localparam logic [OP_W-1:0] OP_TILT_UP     = 5'd2;
  localparam logic [OP_W-1:0] OP_TILT_DOWN   = 5'd3;
  localparam logic [OP_W-1:0] OP_LEFT_UP     = 5'd4;
  localparam logic [OP_W-1:0] OP_LEFT_DOWN   = 5'd5;
  localparam logic [OP_W-1:0] OP_RIGHT_UP    = 5'd6;
  localparam logic [OP_W-1:0] OP_RIGHT_DOWN  = 5'd7;
  localparam logic [OP_W-1:0] OP_TELE        = 5'd8;
  localparam logic [OP_W-1:0] OP_WIDE        = 5'd9;
  localparam logic [OP_W-1:0] OP_IRIS_OPEN   = 5'd10;
  localparam logic [OP_W-1:0] OP_IRIS_CLOSE  = 5'd11;
  localparam logic [OP_W-1:0] OP_FOCUS_FAR   = 5'd12;
  localparam logic [OP_W-1:0] OP_FOCUS_NEAR  = 5'd13;
  localparam logic [OP_W-1:0] OP_PRESET_SET  = 5'd14;
  localparam logic [OP_W-1:0] OP_PRESET_GOTO = 5'd15;
  localparam logic [OP_W-1:0] OP_OTHER       = 5'd16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAM_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_PT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_ZF   = 2'd2;

  localparam logic [BYTE_W-1:0]  CAM_ADDR_RST = 8'd0;
  localparam logic [SPEED_W-1:0] DEF_PT_RST   = 7'd50;
  localparam logic [SPEED_W-1:0] DEF_ZF_RST   = 7'd50;

  // Frame constants
  localparam logic [BYTE_W-1:0] FRAME_HEADER  = 8'h55;
  localparam logic [BYTE_W-1:0] CTRL_ADDR     = 8'h00;
  localparam logic [BYTE_W-1:0] FRAME_TRAILER = 8'hAA;
  localparam logic [BYTE_W-1:0] CHK_BASE      = 8'h20;  // 0x2020 mod 256
  localparam logic [BYTE_W-1:0] PT_OFFSET     = 8'h81;
  localparam logic [BYTE_W-1:0] IRIS_CMD      = 8'h57;
  localparam logic [BYTE_W-1:0] IRIS_SPEED    = 8'h81;
  localparam logic [BYTE_W-1:0] IRIS_OPEN_ARG = 8'h82;
  localparam logic [BYTE_W-1:0] IRIS_CLS_ARG  = 8'h83;
  localparam logic [BYTE_W-1:0] FOCUS_FAR_CMD = 8'h01;
  localparam logic [BYTE_W-1:0] FOCUS_NR_CMD  = 8'h02;
  localparam logic [BYTE_W-1:0] PRESET_SET_CMD  = 8'h03;
  localparam logic [BYTE_W-1:0] PRESET_GOTO_CMD = 8'h07;

  // Byte positions within the frame
  localparam logic [IDX_W-1:0] POS_HEADER  = 4'd0;
  localparam logic [IDX_W-1:0] POS_CTRL    = 4'd1;
  localparam logic [IDX_W-1:0] POS_CAM     = 4'd2;
  localparam logic [IDX_W-1:0] POS_CMD1    = 4'd3;
  localparam logic [IDX_W-1:0] POS_CMD2    = 4'd4;
  localparam logic [IDX_W-1:0] POS_PAN     = 4'd5;
  localparam logic [IDX_W-1:0] POS_TILT    = 4'd6;
  localparam logic [IDX_W-1:0] POS_ZF      = 4'd7;
  localparam logic [IDX_W-1:0] POS_SPARE   = 4'd8;
  localparam logic [IDX_W-1:0] POS_TRAILER = 4'd9;
  localparam logic [IDX_W-1:0] POS_CHK     = 4'd10;

  // x/100 == (x * 5243) >> 19 for x < 16384; fold the 63 and 8 factors in
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 19;
  localparam int PROD_W      = PARAM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] PT_RECIP = 19'd330309;  // 63 * 5243
  localparam logic [RECIP_W-1:0] ZF_RECIP = 19'd41944;   // 8 * 5243

  // Short queue between the classifier and the serializer
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] cam;
    logic [BYTE_W-1:0] cmd1;
    logic [BYTE_W-1:0] cmd2;
    logic [BYTE_W-1:0] pt;
    logic [BYTE_W-1:0] zf;
    logic [BYTE_W-1:0] spare;
  } frame_desc_t;

  typedef struct packed {
    logic        push;
    frame_desc_t desc;
  } queue_wr_t;

  typedef struct packed {
    logic        valid;
    frame_desc_t desc;
  } queue_rd_t;

  function automatic logic [BYTE_W-1:0] motion_code(input logic [3:0] op);
    logic [BYTE_W-1:0] code;
    case (op)
      4'd0:    code = 8'h04;
      4'd1:    code = 8'h02;
      4'd2:    code = 8'h08;
      4'd3:    code = 8'h10;
      4'd4:    code = 8'h0c;
      4'd5:    code = 8'h14;
      4'd6:    code = 8'h0a;
      4'd7:    code = 8'h12;
      4'd8:    code = 8'h20;
      4'd9:    code = 8'h40;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ptzfb_if.sv =====
`default_nettype none
interface ptzfb_in_if;
  import ptzfb_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [PARAM_W-1:0] param;
  modport source (output valid, output op, output param, input ready);
  modport sink   (input valid, input op, input param, output ready);
endinterface

interface ptzfb_out_if;
  import ptzfb_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_byte;
  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface ptzfb_cfg_if;
  import ptzfb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ptzfb_front.sv =====
`default_nettype none
module ptzfb_front (
  input  logic                clk,
  input  logic                rst_n,
  ptzfb_in_if.sink            in_ch,
  ptzfb_cfg_if.sink           cfg_ch,
  input  logic                q_full,
  output ptzfb_pkg::queue_wr_t q_wr
);
  import ptzfb_pkg::*;

  logic [BYTE_W-1:0]  cam_addr_r;
  logic [SPEED_W-1:0] def_pt_r;
  logic [SPEED_W-1:0] def_zf_r;

  logic               cfg_wr;
  logic               accept;
  logic               op_known;
  logic [PARAM_W-1:0] pt_pct;
  logic [PARAM_W-1:0] zf_pct;
  logic [PROD_W-1:0]  pt_prod;
  logic [PROD_W-1:0]  zf_prod;
  logic [BYTE_W-1:0]  pt_speed;
  logic [BYTE_W-1:0]  zf_speed;
  frame_desc_t        desc;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_addr_r <= CAM_ADDR_RST;
      def_pt_r   <= DEF_PT_RST;
      def_zf_r   <= DEF_ZF_RST;
    end else if (cfg_wr) begin
      case (cfg_ch.index)
        REG_CAM_ADDR: cam_addr_r <= cfg_ch.data;
        REG_DEF_PT:   def_pt_r   <= cfg_ch.data[SPEED_W-1:0];
        REG_DEF_ZF:   def_zf_r   <= cfg_ch.data[SPEED_W-1:0];
        default:      ;
      endcase
    end
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Zero parameter selects the default speeds
  assign pt_pct = (in_ch.param != '0) ? in_ch.param : {1'b0, def_pt_r};
  assign zf_pct = (in_ch.param != '0) ? in_ch.param : {1'b0, def_zf_r};

  assign pt_prod = {{RECIP_W{1'b0}}, pt_pct} * {{PARAM_W{1'b0}}, PT_RECIP};
  assign zf_prod = {{RECIP_W{1'b0}}, zf_pct} * {{PARAM_W{1'b0}}, ZF_RECIP};

  assign pt_speed = pt_prod[RECIP_SHIFT+BYTE_W-1:RECIP_SHIFT] + PT_OFFSET;
  assign zf_speed = zf_prod[RECIP_SHIFT+BYTE_W-1:RECIP_SHIFT];

  always_comb begin
    desc     = '0;
    desc.cam = cam_addr_r;
    op_known = 1'b1;
    if (in_ch.op inside {[OP_PAN_LEFT:OP_WIDE]}) begin
      desc.cmd2 = motion_code(in_ch.op[3:0]);
      desc.pt   = pt_speed;
      desc.zf   = zf_speed;
    end else if (in_ch.op inside {OP_FOCUS_FAR, OP_FOCUS_NEAR}) begin
      desc.cmd1 = (in_ch.op == OP_FOCUS_FAR) ? FOCUS_FAR_CMD : FOCUS_NR_CMD;
      desc.pt   = pt_speed;
      desc.zf   = zf_speed;
    end else if (in_ch.op inside {OP_IRIS_OPEN, OP_IRIS_CLOSE}) begin
      desc.cmd2  = IRIS_CMD;
      desc.zf    = IRIS_SPEED;
      desc.spare = (in_ch.op == OP_IRIS_OPEN) ? IRIS_OPEN_ARG : IRIS_CLS_ARG;
    end else if (in_ch.op inside {OP_PRESET_SET, OP_PRESET_GOTO}) begin
      desc.cmd2 = (in_ch.op == OP_PRESET_SET) ? PRESET_SET_CMD : PRESET_GOTO_CMD;
      desc.zf   = in_ch.param;
    end else if (in_ch.op != OP_OTHER) begin
      // drop out-of-range ops: no frame
      op_known = 1'b0;
    end
  end

  assign q_wr.push = accept && op_known;
  assign q_wr.desc = desc;

endmodule
`default_nettype wire

// ===== sv/ptzfb_queue.sv =====
`default_nettype none
module ptzfb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptzfb_pkg::queue_wr_t q_wr,
  input  logic                 pop,
  output logic                 full,
  output ptzfb_pkg::queue_rd_t q_rd
);
  import ptzfb_pkg::*;

  frame_desc_t          slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.desc  = slot_r[rd_ptr_r];
  assign do_push    = q_wr.push && !full;
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wr.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptzfb_back.sv =====
`default_nettype none
module ptzfb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptzfb_pkg::queue_rd_t q_rd,
  output logic                 pop,
  ptzfb_out_if.source          out_ch
);
  import ptzfb_pkg::*;

  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [BYTE_W-1:0] sum_r;
  logic [BYTE_W-1:0] sum_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              load;
  logic              at_last;
  logic [BYTE_W-1:0] cur_byte;

  assign load    = q_rd.valid && (!out_valid_r || out_ch.ready);
  assign at_last = (idx_r == POS_CHK);
  assign pop     = load && at_last;

  always_comb begin
    case (idx_r)
      POS_HEADER:  cur_byte = FRAME_HEADER;
      POS_CTRL:    cur_byte = CTRL_ADDR;
      POS_CAM:     cur_byte = q_rd.desc.cam;
      POS_CMD1:    cur_byte = q_rd.desc.cmd1;
      POS_CMD2:    cur_byte = q_rd.desc.cmd2;
      POS_PAN:     cur_byte = q_rd.desc.pt;
      POS_TILT:    cur_byte = q_rd.desc.pt;
      POS_ZF:      cur_byte = q_rd.desc.zf;
      POS_SPARE:   cur_byte = q_rd.desc.spare;
      POS_TRAILER: cur_byte = FRAME_TRAILER;
      POS_CHK:     cur_byte = CHK_BASE - sum_r;
      default:     cur_byte = '0;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = at_last ? '0 : idx_r + 1'b1;
      sum_nxt       = at_last ? '0 : sum_r + cur_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_last_r <= at_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.last_byte  = out_last_r;

endmodule
`default_nettype wire

// ===== sv/ptz_command_frame_builder_core.sv =====
// A taken request's first byte passes through the queue, then the output register.
// One frame byte per cycle leaves the output register while out_ch.ready holds and a
// descriptor is queued; requests queue two deep, so new ones are taken mid-frame.
// Reset: rst_n synchronous, active low; clears queue, byte index, running sum and
// output valid, and loads the register defaults (address 0, both speeds 50).
`default_nettype none
module ptz_command_frame_builder_core (
  input  logic        clk,
  input  logic        rst_n,
  ptzfb_in_if.sink    in_ch,
  ptzfb_out_if.source out_ch,
  ptzfb_cfg_if.sink   cfg_ch
);
  import ptzfb_pkg::*;

  // Front to queue: classified command, ready for serialization
  queue_wr_t q_wr;
  // Queue to back: head of the queue
  queue_rd_t q_rd;
  logic      q_full;
  logic      q_pop;

  // Classify the op, compute speeds, hold the configuration registers.
  // Drop ops beyond the valid range without pushing anything.
  ptzfb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // Hold up to two frame descriptors so the front keeps taking requests
  // while the back is still streaming a frame.
  ptzfb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  // Stream eleven bytes per descriptor, accumulate the running sum and
  // emit the checksum last; pop the descriptor with the checksum byte.
  ptzfb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ===== sv/ptzfb_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module ptzfb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ptzfb_pkg::BYTE_W-1:0] out_byte,
  input logic                         out_last
);
  import ptzfb_pkg::*;

  logic [BYTE_W-1:0] sum_r;
  logic [IDX_W-1:0]  cnt_r;
  logic              take;
  logic [BYTE_W-1:0] total;

  assign take  = out_valid && out_ready;
  assign total = sum_r + out_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (take) begin
      sum_r <= out_last ? '0 : total;
      cnt_r <= out_last ? '0 : cnt_r + 1'b1;
    end
  end

  `ASSERT_CLKD(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last), "stalled byte changed")
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid after reset")
  `ASSERT_CLKD(a_checksum, clk, rst_n, take && out_last |-> total == CHK_BASE, "bad frame checksum")
  `ASSERT_CLKD(a_frame_len, clk, rst_n, take && out_last |-> cnt_r == POS_CHK, "frame length not eleven")

endmodule

bind ptz_command_frame_builder_core ptzfb_checker u_ptzfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.frame_byte),
  .out_last  (out_ch.last_byte)
);
`default_nettype wire
